/* rtl/wbss_pkg.sv */
// package with shared types and constants for the wildcard byte signature scanner
`timescale 1ns / 1ps
`default_nettype none

package wbss_pkg;

	// pattern capacity, its derived length width, and the address width
	localparam int MaxPattern = 64;
	localparam int LenW       = $clog2(MaxPattern + 1);
	localparam int AddrW      = 32;

	typedef enum logic {
		OP_SIG  = 1'b0,
		OP_DATA = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ACCEPT  = 2'd0,
		ST_REJECT  = 2'd1,
		ST_MATCH   = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	// input transaction payload
	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] value;
		logic       last;
	} item_t;

	// result transaction payload
	typedef struct packed {
		status_t          status;
		logic [AddrW-1:0] match_address;
	} result_t;

	typedef logic [MaxPattern-1:0][7:0] byte_vec_t;
	typedef logic [MaxPattern-1:0]      bit_vec_t;

	// pattern state seen by the scanner
	typedef struct packed {
		logic            valid;
		logic [LenW-1:0] len;
	} pat_info_t;

	// signature end report from the parser
	typedef struct packed {
		logic done;
		logic ok;
	} sig_res_t;

	// scan report for the current data byte
	typedef struct packed {
		logic             hit;
		logic             nomatch;
		logic [AddrW-1:0] addr;
	} scan_res_t;

endpackage

`default_nettype wire

/* rtl/wildcard_byte_signature_scan_top.sv */
// Wildcard byte signature scanner. Takes signature characters or data bytes as
// transactions and returns at most one result per transaction. An accepted
// transaction is held in the input register, and its result is loaded into the
// result register when it leaves the input register. The signature parser and
// the 64-byte masked window compare each finish in the single pass between
// those two registers, so the sustained rate is one transaction per cycle while
// the result side keeps taking. A result held by back-pressure stalls the input
// register until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_signature_scan_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire wbss_pkg::item_t              item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output wbss_pkg::result_t                 result,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [wbss_pkg::AddrW-1:0]   cfg_data
);

	logic                          s1_v;
	wbss_pkg::item_t               item_s1;
	logic                          adv, fire_sig, fire_data, has_res;
	logic [wbss_pkg::AddrW-1:0]    base_q;
	wbss_pkg::byte_vec_t           pat;
	wbss_pkg::bit_vec_t            care;
	wbss_pkg::pat_info_t           info;
	wbss_pkg::sig_res_t            sig_res;
	wbss_pkg::scan_res_t           scan_res;
	wbss_pkg::result_t             res_n;

	// handshake
	assign adv        = s1_v && (!result_valid || result_ready);
	assign item_ready = !s1_v || adv;
	assign fire_sig   = adv && (item_s1.opcode == wbss_pkg::OP_SIG);
	assign fire_data  = adv && (item_s1.opcode == wbss_pkg::OP_DATA);
	assign cfg_ready  = 1'b1;

	// base address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (item_ready) begin
			s1_v <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready) begin
			item_s1 <= item;
		end
	end

	wbss_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire_sig),
		.ch      (item_s1.value),
		.last    (item_s1.last),
		.pat     (pat),
		.care    (care),
		.info    (info),
		.sig_res (sig_res)
	);

	wbss_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_data),
		.data   (item_s1.value),
		.last   (item_s1.last),
		.clear  (sig_res.done),
		.pat    (pat),
		.care   (care),
		.info   (info),
		.base   (base_q),
		.res    (scan_res)
	);

	// result select
	always_comb begin
		has_res             = sig_res.done || scan_res.hit || scan_res.nomatch;
		res_n.match_address = '0;
		priority if (sig_res.done) begin
			res_n.status = sig_res.ok ? wbss_pkg::ST_ACCEPT : wbss_pkg::ST_REJECT;
		end else if (scan_res.hit) begin
			res_n.status        = wbss_pkg::ST_MATCH;
			res_n.match_address = scan_res.addr;
		end else begin
			res_n.status = wbss_pkg::ST_NOMATCH;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!result_valid || result_ready) begin
			result_valid <= adv && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res_n;
		end
	end

	// only a match carries an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != wbss_pkg::ST_MATCH |-> result.match_address == '0)
		else $error("nonzero address on a non-match result");

	// an empty input register always takes a transaction
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v |-> item_ready)
		else $error("input register empty but not ready");

	// a held item stays while the result register is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && result_valid && !result_ready |=> s1_v)
		else $error("input item dropped under backpressure");

	// a result only appears after a transaction left the input register
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(adv))
		else $error("result without a processed transaction");

endmodule

`default_nettype wire

/* rtl/wbss_parse.sv */
// signature parser that builds the right-aligned pattern and care mask
`timescale 1ns / 1ps
`default_nettype none

module wbss_parse (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fire,
	input  wire logic [7:0]             ch,
	input  wire logic                   last,
	output wbss_pkg::byte_vec_t         pat,
	output wbss_pkg::bit_vec_t          care,
	output wbss_pkg::pat_info_t         info,
	output wbss_pkg::sig_res_t          sig_res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_QMARK,
		PH_NIBBLE,
		PH_DONE
	} phase_t;

	localparam logic [7:0] ChQmark = 8'h3F;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoF   = 8'h66;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] Ten     = 8'd10;

	// hex digit decode: {valid, value}
	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= ChZero && c <= ChNine) begin
			d = c - ChZero;
			return {1'b1, d[3:0]};
		end
		if (c >= ChUpA && c <= ChUpF) begin
			d = c - ChUpA + Ten;
			return {1'b1, d[3:0]};
		end
		if (c >= ChLoA && c <= ChLoF) begin
			d = c - ChLoA + Ten;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	phase_t                        phase_q, phase_e, phase_n;
	logic [3:0]                    nib_q, nib_n;
	logic                          err_q, err_e, err_n;
	logic                          valid_q, valid_n;
	logic [wbss_pkg::LenW-1:0]     len_q, len_e, len_n;
	wbss_pkg::bit_vec_t            care_q, care_e, care_n;
	wbss_pkg::byte_vec_t           pat_q;
	logic                          start, is_space, full;
	logic [4:0]                    hx;
	logic                          push, push_wild, do_shift;
	logic [7:0]                    push_byte;

	// next parse state for one signature character
	always_comb begin
		start    = (phase_q == PH_DONE);
		phase_e  = start ? PH_IDLE : phase_q;
		err_e    = start ? 1'b0 : err_q;
		len_e    = start ? '0 : len_q;
		care_e   = start ? '0 : care_q;
		hx       = hex_dec(ch);
		is_space = (ch == ChSpace) || (ch >= ChTab && ch <= ChCr);
		phase_n  = phase_e;
		nib_n    = nib_q;
		err_n    = err_e;
		push      = 1'b0;
		push_wild = 1'b0;
		push_byte = 8'd0;
		if (!err_e) begin
			if (phase_e == PH_NIBBLE) begin
				if (hx[4]) begin
					push      = 1'b1;
					push_byte = {nib_q, hx[3:0]};
					phase_n   = PH_IDLE;
				end else begin
					err_n = 1'b1;
				end
			end else begin
				if (phase_e == PH_QMARK) begin
					phase_n = PH_IDLE;
				end
				priority if (phase_e == PH_QMARK && ch == ChQmark) begin
					// second question mark of a wildcard is absorbed
				end else if (is_space) begin
					// white space between tokens
				end else if (ch == ChQmark) begin
					push      = 1'b1;
					push_wild = 1'b1;
					phase_n   = PH_QMARK;
				end else if (hx[4]) begin
					nib_n   = hx[3:0];
					phase_n = PH_NIBBLE;
				end else begin
					err_n = 1'b1;
				end
			end
		end
		// entry push with overflow check
		full     = (len_e == wbss_pkg::LenW'(wbss_pkg::MaxPattern));
		do_shift = push && !full;
		if (push && full) begin
			err_n = 1'b1;
		end
		len_n  = do_shift ? len_e + 1'b1 : len_e;
		care_n = do_shift ? {!push_wild, care_e[wbss_pkg::MaxPattern-1:1]} : care_e;
		// end of signature
		valid_n = 1'b0;
		if (last) begin
			if (phase_n == PH_NIBBLE || len_n == '0) begin
				err_n = 1'b1;
			end
			valid_n = !err_n;
			phase_n = PH_DONE;
		end
	end

	// parse control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nib_q   <= 4'd0;
			err_q   <= 1'b0;
			valid_q <= 1'b0;
			len_q   <= '0;
			care_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			nib_q   <= nib_n;
			err_q   <= err_n;
			valid_q <= valid_n;
			len_q   <= len_n;
			care_q  <= care_n;
		end
	end

	// pattern bytes, newest entry at the top
	always_ff @(posedge clk) begin
		if (fire && do_shift) begin
			pat_q <= {push_byte, pat_q[wbss_pkg::MaxPattern-1:1]};
		end
	end

	assign pat          = pat_q;
	assign care         = care_q;
	assign info.valid   = valid_q;
	assign info.len     = len_q;
	assign sig_res.done = fire && last;
	assign sig_res.ok   = valid_n;

endmodule

`default_nettype wire

/* rtl/wbss_scan.sv */
// data window and parallel masked compare against the pattern
`timescale 1ns / 1ps
`default_nettype none

module wbss_scan (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire logic [7:0]                   data,
	input  wire logic                         last,
	input  wire logic                         clear,
	input  wire wbss_pkg::byte_vec_t          pat,
	input  wire wbss_pkg::bit_vec_t           care,
	input  wire wbss_pkg::pat_info_t          info,
	input  wire logic [wbss_pkg::AddrW-1:0]   base,
	output wbss_pkg::scan_res_t               res
);

	wbss_pkg::byte_vec_t            win_q, win_n;
	logic [wbss_pkg::AddrW-1:0]     seen_q, seen_n;
	logic                           mr_q;
	wbss_pkg::bit_vec_t             pos_ok;
	logic                           enough, hit;

	// shift in the new byte and compare every position
	always_comb begin
		win_n  = {data, win_q[wbss_pkg::MaxPattern-1:1]};
		seen_n = (&seen_q) ? seen_q : seen_q + 1'b1;
		enough = (|seen_n[wbss_pkg::AddrW-1:wbss_pkg::LenW]) ||
			(seen_n[wbss_pkg::LenW-1:0] >= info.len);
		for (int i = 0; i < wbss_pkg::MaxPattern; i++) begin
			pos_ok[i] = !care[i] || (win_n[i] == pat[i]);
		end
		hit         = info.valid && !mr_q && enough && (&pos_ok);
		res.hit     = fire && hit;
		res.nomatch = fire && !hit && last && !mr_q;
		res.addr    = base + seen_n - wbss_pkg::AddrW'(info.len);
	end

	// run counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			mr_q   <= 1'b0;
		end else if (clear) begin
			seen_q <= '0;
			mr_q   <= 1'b0;
		end else if (fire) begin
			if (last) begin
				seen_q <= '0;
				mr_q   <= 1'b0;
			end else begin
				seen_q <= seen_n;
				mr_q   <= mr_q || hit;
			end
		end
	end

	// byte window
	always_ff @(posedge clk) begin
		if (fire) begin
			win_q <= win_n;
		end
	end

endmodule

`default_nettype wire

/* tb/sv/signature_scan_checker.sv */
// checker that predicts and compares the signature scanner results
`timescale 1ns / 1ps

module signature_scan_checker
	import wbss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  item_t            item,
	input  logic             result_valid,
	input  logic             result_ready,
	input  result_t          result,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [AddrW-1:0] cfg_data,
	output int               failures,
	output int               outstanding,
	output int               results_seen,
	output int               matches_seen
);

	typedef enum logic [1:0] {
		PARSE_IDLE,
		PARSE_QMARK,
		PARSE_NIBBLE,
		PARSE_DONE
	} parse_phase_t;

	// predicted pattern and parser state
	logic [7:0]            sig_bytes [MaxPattern];
	logic [MaxPattern-1:0] sig_wild;
	int unsigned           sig_len;
	bit                    sig_ok;
	bit                    sig_err;
	parse_phase_t          phase;
	logic [3:0]            hi_nibble;

	// predicted scan state
	logic [7:0]       window [MaxPattern];
	logic [AddrW-1:0] run_bytes;
	bit               run_matched;
	logic [AddrW-1:0] base_addr;

	// results still owed by the block, oldest first
	result_t expected_reports[$];
	result_t predicted;
	result_t oldest;
	bit      produced;
	int      n_fail;
	int      n_results;
	int      n_matches;

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - "0");
		if (c >= "A" && c <= "F")
			return int'(c - "A") + 10;
		if (c >= "a" && c <= "f")
			return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void clear_run();
		foreach (window[i])
			window[i] = 8'h00;
		run_bytes   = '0;
		run_matched = 1'b0;
	endfunction

	function automatic void add_entry(input logic [7:0] b, input bit wild);
		if (sig_len >= MaxPattern) begin
			sig_err = 1'b1;
			return;
		end
		sig_bytes[sig_len] = b;
		sig_wild[sig_len]  = wild;
		sig_len++;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		int h;
		if (sig_err)
			return;
		// second digit of a byte
		if (phase == PARSE_NIBBLE) begin
			h = hex_digit(c);
			if (h < 0) begin
				sig_err = 1'b1;
				return;
			end
			add_entry({hi_nibble, h[3:0]}, 1'b0);
			phase = PARSE_IDLE;
			return;
		end
		// a question mark right after a wildcard is swallowed
		if (phase == PARSE_QMARK) begin
			phase = PARSE_IDLE;
			if (c == "?")
				return;
		end
		if (is_blank(c))
			return;
		if (c == "?") begin
			add_entry(8'h00, 1'b1);
			phase = PARSE_QMARK;
			return;
		end
		h = hex_digit(c);
		if (h < 0) begin
			sig_err = 1'b1;
			return;
		end
		hi_nibble = h[3:0];
		phase     = PARSE_NIBBLE;
	endfunction

	function automatic bit window_hit();
		int unsigned off;
		if (sig_len == 0 || sig_len > MaxPattern)
			return 1'b0;
		off = MaxPattern - sig_len;
		for (int unsigned i = 0; i < sig_len; i++) begin
			if (!sig_wild[i] && window[off + i] != sig_bytes[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void reset_scan_model();
		foreach (sig_bytes[i])
			sig_bytes[i] = 8'h00;
		sig_wild  = '0;
		sig_len   = 0;
		sig_ok    = 1'b0;
		sig_err   = 1'b0;
		phase     = PARSE_IDLE;
		hi_nibble = 4'h0;
		base_addr = '0;
		clear_run();
	endfunction

	// returns 1 when the transaction yields a result, placed in rep
	function automatic bit predict_report(input item_t it, output result_t rep);
		bit had;
		rep = '0;
		if (it.opcode == OP_SIG) begin
			// first character after an end starts a fresh signature
			if (phase == PARSE_DONE) begin
				sig_wild  = '0;
				sig_len   = 0;
				sig_err   = 1'b0;
				hi_nibble = 4'h0;
				phase     = PARSE_IDLE;
			end
			sig_ok = 1'b0;
			parse_char(it.value);
			if (!it.last)
				return 1'b0;
			if (phase == PARSE_NIBBLE || sig_len == 0)
				sig_err = 1'b1;
			sig_ok = !sig_err;
			phase  = PARSE_DONE;
			clear_run();
			rep.status = sig_ok ? ST_ACCEPT : ST_REJECT;
			return 1'b1;
		end
		// shift the byte into the window
		for (int i = 0; i < MaxPattern - 1; i++)
			window[i] = window[i + 1];
		window[MaxPattern - 1] = it.value;
		if (run_bytes != '1)
			run_bytes++;
		if (sig_ok && !run_matched && run_bytes >= sig_len && window_hit()) begin
			run_matched       = 1'b1;
			rep.status        = ST_MATCH;
			rep.match_address = base_addr + (run_bytes - AddrW'(sig_len));
			if (it.last)
				clear_run();
			return 1'b1;
		end
		if (it.last) begin
			had = run_matched;
			clear_run();
			if (!had) begin
				rep.status = ST_NOMATCH;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_scan_model();
			expected_reports.delete();
			n_fail       = 0;
			n_results    = 0;
			n_matches    = 0;
			failures     <= 0;
			outstanding  <= 0;
			results_seen <= 0;
			matches_seen <= 0;
		end else begin
			// compare a result transaction with the oldest prediction
			if (result_valid && result_ready) begin
				n_results++;
				if (result.status == ST_MATCH)
					n_matches++;
				if (expected_reports.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("%0t: unexpected result status %0d address %h",
							$time, result.status, result.match_address);
				end else begin
					oldest = expected_reports.pop_front();
					if (result.status !== oldest.status ||
						result.match_address !== oldest.match_address) begin
						n_fail++;
						if (n_fail <= 10)
							$display("%0t: status exp %0d got %0d, address exp %h got %h",
								$time, oldest.status, result.status,
								oldest.match_address, result.match_address);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				base_addr = cfg_data;
			if (item_valid && item_ready) begin
				produced = predict_report(item, predicted);
				if (produced)
					expected_reports = {expected_reports, predicted};
			end
			failures     <= n_fail;
			outstanding  <= expected_reports.size();
			results_seen <= n_results;
			matches_seen <= n_matches;
		end
	end

endmodule

/* tb/sv/tb_wildcard_byte_signature_scan_top.sv */
// testbench top for the wildcard byte signature scanner
`timescale 1ns / 1ps

module tb_wildcard_byte_signature_scan_top;
	import wbss_pkg::*;

	localparam int ItemTarget   = 820;
	localparam int IdleLimit    = 3000;
	localparam int SettleCycles = 4;

	typedef enum int {
		SIG_CLEAN,
		SIG_BAD_CHAR,
		SIG_ODD_DIGIT,
		SIG_EMPTY,
		SIG_OVERFLOW
	} sig_flaw_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	item_t            item         = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_t          result;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [AddrW-1:0] cfg_data     = '0;

	int fail_count;
	int pending_reports;
	int reports_seen;
	int matches_seen;
	int items_sent  = 0;
	int sigs_sent   = 0;
	int cfg_writes  = 0;
	int idle_cycles = 0;
	bit steady      = 1'b0;

	// signature text being sent and the pattern it encodes
	logic [7:0] sig_text[$];
	logic [7:0] pat_byte[$];
	bit         pat_wild[$];
	bit         pat_good;

	always #4 clk = ~clk;

	wildcard_byte_signature_scan_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	signature_scan_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.failures     (fail_count),
		.outstanding  (pending_reports),
		.results_seen (reports_seen),
		.matches_seen (matches_seen)
	);

	// count cycles with no transaction on any channel
	always @(posedge clk) begin
		if (arst_n && !((item_valid && item_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready)))
			idle_cycles <= idle_cycles + 1;
		else
			idle_cycles <= 0;
	end

	initial begin
		wait (idle_cycles >= IdleLimit);
		$display("FAILURE");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side back-pressure
	initial begin
		int gap;
		forever begin
			result_ready <= 1'b1;
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(40, 150)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 6)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0)
					result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	task automatic push_item(input opcode_t op, input logic [7:0] v, input bit l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{opcode: op, value: v, last: l};
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	// hold the sender until every owed result is back and the pipe is quiet
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_base(input logic [AddrW-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic send_text();
		sigs_sent++;
		foreach (sig_text[i])
			push_item(OP_SIG, sig_text[i], i == sig_text.size() - 1);
	endtask

	function automatic logic [AddrW-1:0] pick_base();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			2:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10)
			return "0" + n;
		return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0:       return 8'h09;
			1:       return 8'h0A;
			2:       return 8'h0B;
			3:       return 8'h0C;
			4:       return 8'h0D;
			default: return 8'h20;
		endcase
	endfunction

	// any character that is not a digit, blank or question mark
	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f") ||
			c == "?" || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D));
		return c;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 4);
		if (r < 92)
			return $urandom_range(5, 12);
		if (r < 98)
			return $urandom_range(13, 40);
		return MaxPattern;
	endfunction

	// build a pattern and its text, with the requested flaw
	task automatic build_signature(input sig_flaw_t flaw, input int want_len);
		int  n;
		int  pos;
		bit  single_q;
		n = want_len;
		if (n == 0)
			n = (flaw == SIG_OVERFLOW) ? MaxPattern + $urandom_range(1, 2) : pick_len();
		if (flaw == SIG_EMPTY)
			n = 0;
		pat_byte.delete();
		pat_wild.delete();
		sig_text.delete();
		single_q = 1'b0;
		for (int i = 0; i < n; i++) begin
			pat_wild = {pat_wild, ($urandom_range(0, 3) == 0)};
			pat_byte = {pat_byte, 8'($urandom_range(0, 255))};
			// a lone question mark before a wildcard needs a blank between
			if ($urandom_range(0, 3) == 0 || (single_q && pat_wild[i])) begin
				repeat ($urandom_range(1, 2)) sig_text = {sig_text, blank_char()};
			end
			if (pat_wild[i]) begin
				sig_text = {sig_text, 8'("?")};
				single_q = $urandom_range(0, 1);
				if (!single_q)
					sig_text = {sig_text, 8'("?")};
			end else begin
				sig_text = {sig_text, hex_char(pat_byte[i][7:4])};
				sig_text = {sig_text, hex_char(pat_byte[i][3:0])};
				single_q = 1'b0;
			end
		end
		if (n == 0 || $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) sig_text = {sig_text, blank_char()};
		pos = $urandom_range(0, sig_text.size());
		case (flaw)
			SIG_BAD_CHAR:  sig_text.insert(pos, bad_char());
			SIG_ODD_DIGIT: sig_text.insert(pos, hex_char(4'($urandom_range(0, 15))));
			default: ;
		endcase
		pat_good = flaw == SIG_CLEAN && n > 0 && n <= MaxPattern;
	endtask

	// one data run, often with the pattern planted somewhere in it
	task automatic run_data();
		logic [7:0] run[$];
		int         len;
		int         plen;
		int         at;
		bit         plant;
		plen  = pat_byte.size();
		len   = $urandom_range(1, 16);
		plant = pat_good && $urandom_range(0, 3) != 0;
		if (plant && len < plen)
			len = plen + $urandom_range(0, 8);
		repeat (len) run = {run, 8'($urandom_range(0, 255))};
		if (plant) begin
			repeat ($urandom_range(1, 2)) begin
				at = ($urandom_range(0, 3) == 0) ? len - plen : $urandom_range(0, len - plen);
				for (int i = 0; i < plen; i++) begin
					if (!pat_wild[i])
						run[at + i] = pat_byte[i];
				end
			end
		end
		foreach (run[i])
			push_item(OP_DATA, run[i], i == len - 1);
	endtask

	// unstructured transactions, signature and data mixed
	task automatic send_noise();
		repeat ($urandom_range(4, 12))
			push_item(opcode_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				$urandom_range(0, 3) == 0);
	endtask

	initial begin
		int        scen;
		int        r;
		sig_flaw_t flaw;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base(32'h0000_1000);

		// data with no pattern loaded
		push_item(OP_DATA, 8'h00, 1'b1);
		// wildcard pair, tab, both letter cases
		sig_text = '{"?", "?", "9", "a", 8'h09, "F", "f"};
		send_text();
		// match completed on the closing byte
		push_item(OP_DATA, 8'h11, 1'b0);
		push_item(OP_DATA, 8'h9A, 1'b0);
		push_item(OP_DATA, 8'hFF, 1'b1);
		// match address wraps past the top of the address space
		write_base(32'hFFFF_FFFF);
		push_item(OP_DATA, 8'h00, 1'b0);
		push_item(OP_DATA, 8'h9A, 1'b0);
		push_item(OP_DATA, 8'h9A, 1'b0);
		push_item(OP_DATA, 8'hFF, 1'b0);
		push_item(OP_DATA, 8'h00, 1'b1);
		// unpaired digit, bad letter, nul, empty, high byte
		push_item(OP_SIG, "A", 1'b1);
		push_item(OP_SIG, "G", 1'b1);
		push_item(OP_SIG, 8'h00, 1'b1);
		push_item(OP_SIG, 8'h20, 1'b1);
		push_item(OP_SIG, 8'hFF, 1'b1);
		// data against a rejected pattern
		push_item(OP_DATA, 8'hFF, 1'b1);

		// random signatures, each followed by a few data runs
		scen = 0;
		while (items_sent < ItemTarget) begin
			steady = $urandom_range(0, 5) == 0;
			if ($urandom_range(0, 4) == 0)
				write_base(pick_base());
			r = $urandom_range(0, 99);
			if (scen == 0)
				build_signature(SIG_OVERFLOW, 0);
			else if (scen == 1)
				build_signature(SIG_CLEAN, MaxPattern);
			else if (r >= 95) begin
				send_noise();
				scen++;
				continue;
			end else begin
				flaw = r < 70 ? SIG_CLEAN : r < 78 ? SIG_BAD_CHAR : r < 86 ? SIG_ODD_DIGIT :
					r < 92 ? SIG_EMPTY : SIG_OVERFLOW;
				build_signature(flaw, 0);
			end
			send_text();
			repeat ($urandom_range(1, 3)) run_data();
			scen++;
		end

		steady = 1'b0;
		drain();
		$display("sent %0d transactions in %0d signatures, checked %0d results, %0d matches",
			items_sent, sigs_sent, reports_seen, matches_seen);
		$display("%0d base address settings, %0d mismatches", cfg_writes, fail_count);
		if (fail_count == 0 && pending_reports == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* wildcard_byte_signature_scan_top.f */
rtl/wbss_pkg.sv
rtl/wbss_parse.sv
rtl/wbss_scan.sv
rtl/wildcard_byte_signature_scan_top.sv
tb/sv/signature_scan_checker.sv
tb/sv/tb_wildcard_byte_signature_scan_top.sv
